// File: hw/rtl/http_response_body_extractor_top_assert.svh
// assertion macros for the body extractor checker
`ifndef HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH
`define HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HRBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define HRBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hrbe_pkg.sv
// shared types, constants and byte parsing functions of the body extractor
package hrbe_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [31:0] DEFAULT_BODY_LENGTH = 32'd100;

  localparam int LEN_NAME_LEN  = 14;
  localparam int ENC_NAME_LEN  = 17;
  localparam int ENC_VALUE_LEN = 8;
  localparam logic [8*LEN_NAME_LEN-1:0]  LEN_NAME  = "Content-Length";
  localparam logic [8*ENC_NAME_LEN-1:0]  ENC_NAME  = "Transfer-Encoding";
  localparam logic [8*ENC_VALUE_LEN-1:0] ENC_VALUE = " chunked";

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_UX    = 8'h58;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_BODY    = 6'b000010,
    PH_CSIZE   = 6'b000100,
    PH_CDATA   = 6'b001000,
    PH_CSKIP   = 6'b010000,
    PH_ENDPEND = 6'b100000
  } phase_e;

  typedef enum logic [4:0] {
    SC_BLANK  = 5'b00001,
    SC_SIGN   = 5'b00010,
    SC_PREFIX = 5'b00100,
    SC_DIGITS = 5'b01000,
    SC_DONE   = 5'b10000
  } scan_stage_e;

  typedef struct packed {
    logic [7:0] data;
    logic       cr;
    logic       lf;
    logic       colon;
    logic       blank;
    logic       sign;
    logic       minus;
    logic       x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } byte_class_t;

  typedef struct packed {
    scan_stage_e stage;
    logic        neg;
    logic [31:0] acc;
  } scan_t;

  typedef struct packed {
    logic       colon_seen;
    logic       line_empty;
    logic [4:0] name_pos;
    logic       len_match;
    logic       enc_match;
    logic [3:0] val_pos;
    logic       chk_match;
    scan_t      scan;
  } line_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       chunked;
  } result_t;

  localparam scan_t SCAN_INIT = '{stage: SC_BLANK, neg: 1'b0, acc: 32'd0};
  localparam line_t LINE_INIT = '{colon_seen: 1'b0, line_empty: 1'b1, name_pos: 5'd0,
                                  len_match: 1'b1, enc_match: 1'b1, val_pos: 4'd0,
                                  chk_match: 1'b1, scan: SCAN_INIT};

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t c;
    logic lo_hex;
    logic up_hex;
    c.data   = b;
    c.cr     = (b == CHAR_CR);
    c.lf     = (b == CHAR_LF);
    c.colon  = (b == CHAR_COLON);
    c.blank  = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    c.sign   = (b == CHAR_PLUS) || (b == CHAR_MINUS);
    c.minus  = (b == CHAR_MINUS);
    c.x      = (b == CHAR_LX) || (b == CHAR_UX);
    c.dec_ok = (b >= 8'h30) && (b <= 8'h39);
    lo_hex   = (b >= 8'h61) && (b <= 8'h66);
    up_hex   = (b >= 8'h41) && (b <= 8'h46);
    c.hex_ok = c.dec_ok || lo_hex || up_hex;
    c.digit  = c.dec_ok ? b[3:0] : 4'(b[3:0] + 4'd9);
    return c;
  endfunction

  function automatic scan_t scan_step(scan_t s, byte_class_t c, logic hex);
    scan_t       r;
    logic        ok;
    logic [35:0] v;
    logic [31:0] acc_n;
    r  = s;
    ok = hex ? c.hex_ok : c.dec_ok;
    v  = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {32'd0, c.digit};
    if (hex) begin
      acc_n = (s.acc[31:28] != 4'd0) ? '1 : {s.acc[27:0], c.digit};
    end else begin
      acc_n = (v[35:32] != 4'd0) ? '1 : v[31:0];
    end
    case (s.stage)
      SC_BLANK, SC_SIGN: begin
        if (s.stage == SC_BLANK && c.blank) begin
          r.stage = SC_BLANK;
        end else if (s.stage == SC_BLANK && c.sign) begin
          r.stage = SC_SIGN;
          r.neg   = c.minus;
        end else if (ok) begin
          r.acc   = {28'd0, c.digit};
          r.stage = (hex && c.digit == 4'd0) ? SC_PREFIX : SC_DIGITS;
        end else begin
          r.stage = SC_DONE;
        end
      end
      SC_PREFIX: begin
        if (c.x) begin
          r.stage = SC_DIGITS;
        end else if (ok) begin
          r.acc   = acc_n;
          r.stage = SC_DIGITS;
        end else begin
          r.stage = SC_DONE;
        end
      end
      SC_DIGITS: begin
        if (ok) begin
          r.acc = acc_n;
        end else begin
          r.stage = SC_DONE;
        end
      end
      default: begin
        r.stage = SC_DONE;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] scan_value(scan_t s);
    return s.neg ? 32'd0 : s.acc;
  endfunction

  function automatic line_t hdr_char(line_t s, byte_class_t c);
    line_t      r;
    int         li;
    int         ei;
    int         vi;
    logic [7:0] lc;
    logic [7:0] ec;
    logic [7:0] vc;
    r  = s;
    li = (int'(s.name_pos) < LEN_NAME_LEN) ? int'(s.name_pos) : 0;
    ei = (int'(s.name_pos) < ENC_NAME_LEN) ? int'(s.name_pos) : 0;
    vi = (int'(s.val_pos) < ENC_VALUE_LEN) ? int'(s.val_pos) : 0;
    lc = LEN_NAME[8*(LEN_NAME_LEN-1-li) +: 8];
    ec = ENC_NAME[8*(ENC_NAME_LEN-1-ei) +: 8];
    vc = ENC_VALUE[8*(ENC_VALUE_LEN-1-vi) +: 8];
    if (!s.colon_seen) begin
      if (c.colon) begin
        r.colon_seen = 1'b1;
        r.scan       = SCAN_INIT;
      end else begin
        r.line_empty = 1'b0;
        r.len_match  = s.len_match && (int'(s.name_pos) < LEN_NAME_LEN) && (c.data == lc);
        r.enc_match  = s.enc_match && (int'(s.name_pos) < ENC_NAME_LEN) && (c.data == ec);
        if (s.name_pos != 5'd31) r.name_pos = 5'(s.name_pos + 5'd1);
      end
    end else begin
      r.chk_match = s.chk_match && (int'(s.val_pos) < ENC_VALUE_LEN) && (c.data == vc);
      if (s.val_pos != 4'd15) r.val_pos = 4'(s.val_pos + 4'd1);
      r.scan = scan_step(s.scan, c, 1'b0);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/hrbe_fifo.sv
// small register queue used between front and back and at the result side
module hrbe_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    if (do_pop)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    if (do_push && !do_pop) cnt_d = CntW'(cnt_q + 1'b1);
    if (!do_push && do_pop) cnt_d = CntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end
endmodule

// File: hw/rtl/hrbe_front.sv
// front part: classifies each incoming byte for the parser
module hrbe_front (
  input  logic [7:0]               byte_i,
  output hrbe_pkg::byte_class_t    class_o
);
  import hrbe_pkg::*;

  assign class_o = classify(byte_i);
endmodule

// File: hw/rtl/hrbe_engine.sv
// back part: header and body parser state machine
module hrbe_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  ready_i,
  input  hrbe_pkg::byte_class_t class_i,
  input  logic [31:0]           default_len_i,
  output logic                  take_o,
  output logic                  res_valid_o,
  output hrbe_pkg::result_t     res_o
);
  import hrbe_pkg::*;

  phase_e      phase_q, phase_d;
  logic        prev_cr_q, prev_cr_d;
  line_t       line_q, line_d;
  logic [31:0] decl_len_q, decl_len_d;
  logic        len_given_q, len_given_d;
  logic        chunked_q, chunked_d;
  logic [31:0] rem_q, rem_d;
  logic        final_q, final_d;
  byte_class_t cr_class;

  assign cr_class = classify(CHAR_CR);
  assign take_o   = valid_i && ready_i;

  always_comb begin
    line_t       ln;
    scan_t       sc;
    logic [31:0] len;
    logic [31:0] v;
    logic        hit_end;
    phase_d     = phase_q;
    prev_cr_d   = prev_cr_q;
    line_d      = line_q;
    decl_len_d  = decl_len_q;
    len_given_d = len_given_q;
    chunked_d   = chunked_q;
    rem_d       = rem_q;
    final_d     = final_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: 1'b0, data: class_i.data, chunked: chunked_q};
    ln          = line_q;
    sc          = line_q.scan;
    len         = len_given_q ? decl_len_q : default_len_i;
    v           = scan_value(line_q.scan);
    hit_end     = 1'b0;
    if (take_o) begin
      case (phase_q)
        PH_HEADER: begin
          if (prev_cr_q) begin
            prev_cr_d = 1'b0;
            if (class_i.lf) hit_end = 1'b1;
            else ln = hdr_char(ln, cr_class);
          end
          if (!hit_end) begin
            if (class_i.cr) prev_cr_d = 1'b1;
            else ln = hdr_char(ln, class_i);
            line_d = ln;
          end else if (line_q.line_empty && !line_q.colon_seen) begin
            line_d = LINE_INIT;
            if (chunked_q) begin
              phase_d = PH_CSIZE;
            end else if (len == 32'd0) begin
              res_valid_o = 1'b1;
              res_o       = '{kind: 1'b1, data: 8'd0, chunked: chunked_q};
              len_given_d = 1'b0;
              rem_d       = '0;
              final_d     = 1'b0;
            end else begin
              phase_d = PH_BODY;
              rem_d   = len;
            end
          end else begin
            if (line_q.colon_seen) begin
              if (line_q.len_match && line_q.name_pos == 5'(LEN_NAME_LEN)) begin
                decl_len_d  = v;
                len_given_d = 1'b1;
              end
              if (line_q.enc_match && line_q.name_pos == 5'(ENC_NAME_LEN) &&
                  line_q.chk_match && line_q.val_pos == 4'(ENC_VALUE_LEN)) begin
                chunked_d = 1'b1;
              end
            end
            line_d = LINE_INIT;
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          rem_d       = rem_q - 32'd1;
          if (rem_q <= 32'd1) begin
            rem_d   = '0;
            phase_d = PH_ENDPEND;
          end
        end
        PH_CSIZE: begin
          if (prev_cr_q) begin
            prev_cr_d = 1'b0;
            if (class_i.lf) hit_end = 1'b1;
            else sc = scan_step(sc, cr_class, 1'b1);
          end
          if (hit_end) begin
            line_d.scan = SCAN_INIT;
            if (v == 32'd0) begin
              final_d = 1'b1;
              rem_d   = 32'd2;
              phase_d = PH_CSKIP;
            end else begin
              rem_d   = v;
              phase_d = PH_CDATA;
            end
          end else begin
            if (class_i.cr) prev_cr_d = 1'b1;
            else sc = scan_step(sc, class_i, 1'b1);
            line_d.scan = sc;
          end
        end
        PH_CDATA: begin
          res_valid_o = 1'b1;
          rem_d       = rem_q - 32'd1;
          if (rem_q <= 32'd1) begin
            rem_d   = 32'd2;
            phase_d = PH_CSKIP;
          end
        end
        PH_CSKIP: begin
          rem_d = rem_q - 32'd1;
          if (rem_q <= 32'd1) begin
            if (final_q) begin
              res_valid_o = 1'b1;
              res_o       = '{kind: 1'b1, data: 8'd0, chunked: chunked_q};
              phase_d     = PH_HEADER;
              prev_cr_d   = 1'b0;
              line_d      = LINE_INIT;
              chunked_d   = 1'b0;
              len_given_d = 1'b0;
              rem_d       = '0;
              final_d     = 1'b0;
            end else begin
              line_d.scan = SCAN_INIT;
              prev_cr_d   = 1'b0;
              rem_d       = '0;
              phase_d     = PH_CSIZE;
            end
          end
        end
        PH_ENDPEND: begin
          res_valid_o = 1'b1;
          res_o       = '{kind: 1'b1, data: 8'd0, chunked: chunked_q};
          phase_d     = PH_HEADER;
          chunked_d   = 1'b0;
          len_given_d = 1'b0;
          rem_d       = '0;
          final_d     = 1'b0;
          prev_cr_d   = class_i.cr;
          line_d      = class_i.cr ? LINE_INIT : hdr_char(LINE_INIT, class_i);
        end
        default: begin
          phase_d     = PH_HEADER;
          prev_cr_d   = 1'b0;
          line_d      = LINE_INIT;
          chunked_d   = 1'b0;
          len_given_d = 1'b0;
          rem_d       = '0;
          final_d     = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      prev_cr_q   <= 1'b0;
      line_q      <= LINE_INIT;
      decl_len_q  <= '0;
      len_given_q <= 1'b0;
      chunked_q   <= 1'b0;
      rem_q       <= '0;
      final_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      prev_cr_q   <= prev_cr_d;
      line_q      <= line_d;
      decl_len_q  <= decl_len_d;
      len_given_q <= len_given_d;
      chunked_q   <= chunked_d;
      rem_q       <= rem_d;
      final_q     <= final_d;
    end
  end
endmodule

// File: hw/rtl/http_response_body_extractor_top.sv
// top level of the http response body extractor
//
// input channel: stream_byte_i is taken at a clock edge with push high and
// full low, one byte of an http response per transfer.
// result channel: while empty is low the oldest result sits on
// result_kind_o, body_byte_o and chunked_mode_o; pop high takes it.
// result_kind_o is 0 for a body byte and 1 for the end-of-body marker.
// config: cfg_we_i high writes cfg_wdata_i as the default body length,
// used at the next header end that carries no Content-Length line.
// throughput: one byte per cycle; the parser takes a byte from the middle
// queue each cycle that the result queue has room.
// result path: a result enters the result queue at the edge at which the parser takes its byte.
// when pop stays low the result queue fills, then the middle queue, and
// full rises; no transfer is lost.
// reset: both queues empty, parser back in header parsing, default body
// length 100.
module http_response_body_extractor_top #(
  parameter int QueueDepth = hrbe_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [7:0]  body_byte_o,
  output logic        chunked_mode_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import hrbe_pkg::*;

  logic [31:0] default_len_q;
  byte_class_t front_class;
  byte_class_t mid_class;
  logic        mid_empty;
  logic        out_full;
  logic        take;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_len_q <= DEFAULT_BODY_LENGTH;
    end else if (cfg_we_i) begin
      default_len_q <= cfg_wdata_i;
    end
  end

  hrbe_front u_front (
    .byte_i  (stream_byte_i),
    .class_o (front_class)
  );

  hrbe_fifo #(
    .Width ($bits(byte_class_t)),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (front_class),
    .pop_i   (take),
    .empty_o (mid_empty),
    .data_o  (mid_class)
  );

  hrbe_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!mid_empty),
    .ready_i       (!out_full),
    .class_i       (mid_class),
    .default_len_i (default_len_q),
    .take_o        (take),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  hrbe_fifo #(
    .Width ($bits(result_t)),
    .Depth (QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .full_o  (out_full),
    .data_i  (res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign body_byte_o    = out_res.data;
  assign chunked_mode_o = out_res.chunked;
endmodule

// File: hw/rtl/hrbe_checker.sv
// port checker for the body extractor and its bind
`include "http_response_body_extractor_top_assert.svh"

module hrbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        result_kind_o,
  input logic [7:0]  body_byte_o,
  input logic        chunked_mode_o
);
  `HRBE_ASSERT_NOW(a_end_marker_zero, !empty && result_kind_o, body_byte_o == 8'd0,
                   "end marker carries a nonzero byte")
  `HRBE_ASSERT_NEXT(a_result_holds, !empty && !pop,
                    !empty && $stable(result_kind_o) && $stable(body_byte_o),
                    "waiting result changed")
  `HRBE_ASSERT_NEXT(a_mode_steady, !empty && pop && !result_kind_o,
                    empty || chunked_mode_o == $past(chunked_mode_o),
                    "chunked mode changed inside a body")
  `HRBE_ASSERT_NOW(a_flags_known, 1'b1,
                   !$isunknown(push) && !$isunknown(full) && !$isunknown(empty),
                   "handshake flag unknown")
endmodule

bind http_response_body_extractor_top hrbe_checker u_hrbe_checker (.*);

// File: tb/sv/tb_http_response_body_extractor_checker.sv
// checker for the http response body extractor: predicts results from transfers and compares
`timescale 1ns / 1ps
module tb_http_response_body_extractor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  stream_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        result_kind_o,
  input  logic [7:0]  body_byte_o,
  input  logic        chunked_mode_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import hrbe_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       chunked;
  } body_result_t;

  body_result_t expected_q[$];

  logic [31:0] dflt_len;
  phase_e      phase;
  logic        prev_cr, colon_seen, line_empty, len_match, enc_match, chk_match;
  logic [4:0]  name_pos;
  logic [3:0]  val_pos;
  logic [2:0]  scan_stage;
  logic        scan_neg;
  logic [31:0] scan_acc;
  logic [31:0] decl_len, remaining;
  logic        chunked, final_chunk, len_given;

  localparam logic [2:0] ST_BLANK = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_PREFIX = 3'd2;
  localparam logic [2:0] ST_DIGITS = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  assign pending_o = expected_q.size();

  function automatic int digit_val(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return 255;
  endfunction

  task automatic number_clear();
    scan_stage = ST_BLANK;
    scan_neg = 1'b0;
    scan_acc = '0;
  endtask

  task automatic number_char(logic [7:0] c, bit hex);
    int d;
    int base;
    logic [63:0] v;
    base = hex ? 16 : 10;
    d = digit_val(c, hex);
    if (scan_stage == ST_BLANK) begin
      if (c == " " || (c >= 8'h09 && c <= 8'h0d)) return;
      scan_stage = ST_FIRST;
      if (c == "+" || c == "-") begin
        scan_neg = (c == "-");
        return;
      end
    end
    v = 64'(scan_acc) * base + d;
    case (scan_stage)
      ST_FIRST: begin
        if (d < base) begin
          scan_acc = 32'(d);
          scan_stage = (hex && d == 0) ? ST_PREFIX : ST_DIGITS;
        end else scan_stage = ST_DONE;
      end
      ST_PREFIX: begin
        if (c == "x" || c == "X") scan_stage = ST_DIGITS;
        else if (d < base) begin
          scan_acc = v > 64'hffffffff ? '1 : v[31:0];
          scan_stage = ST_DIGITS;
        end else scan_stage = ST_DONE;
      end
      ST_DIGITS: begin
        if (d < base) scan_acc = v > 64'hffffffff ? '1 : v[31:0];
        else scan_stage = ST_DONE;
      end
      default: scan_stage = ST_DONE;
    endcase
  endtask

  function automatic logic [31:0] number_value();
    return scan_neg ? 32'd0 : scan_acc;
  endfunction

  task automatic line_clear();
    prev_cr = 0; colon_seen = 0; line_empty = 1; name_pos = 0;
    len_match = 1; enc_match = 1; val_pos = 0; chk_match = 1;
    number_clear();
  endtask

  task automatic response_clear();
    line_clear();
    phase = PH_HEADER;
    decl_len = dflt_len;
    chunked = 0; remaining = 0; final_chunk = 0; len_given = 0;
  endtask

  task automatic push_result(logic kind, logic [7:0] data);
    expected_q.push_back('{kind: kind, data: data, chunked: chunked});
  endtask

  task automatic header_byte(logic [7:0] c);
    string ln, en, ev;
    ln = "Content-Length";
    en = "Transfer-Encoding";
    ev = " chunked";
    if (!colon_seen) begin
      if (c == ":") begin
        colon_seen = 1;
        number_clear();
        return;
      end
      line_empty = 0;
      len_match = len_match && name_pos < 14 && c == ln[name_pos < 14 ? name_pos : 0];
      enc_match = enc_match && name_pos < 17 && c == en[name_pos < 17 ? name_pos : 0];
      if (name_pos != 5'd31) name_pos++;
      return;
    end
    chk_match = chk_match && val_pos < 8 && c == ev[val_pos < 8 ? val_pos : 0];
    if (val_pos != 4'd15) val_pos++;
    number_char(c, 0);
  endtask

  task automatic line_done();
    if (line_empty && !colon_seen) begin
      if (!len_given) decl_len = dflt_len;
      line_clear();
      if (chunked) begin
        phase = PH_CSIZE;
      end else if (decl_len == 0) begin
        push_result(1, 0);
        response_clear();
      end else begin
        phase = PH_BODY;
        remaining = decl_len;
      end
      return;
    end
    if (colon_seen) begin
      if (len_match && name_pos == 14) begin
        decl_len = number_value();
        len_given = 1;
      end
      if (enc_match && name_pos == 17 && chk_match && val_pos == 8) chunked = 1;
    end
    line_clear();
  endtask

  task automatic header_input(logic [7:0] c);
    if (prev_cr) begin
      prev_cr = 0;
      if (c == 8'h0a) begin
        line_done();
        return;
      end
      header_byte(8'h0d);
    end
    if (c == 8'h0d) prev_cr = 1;
    else header_byte(c);
  endtask

  task automatic predict_byte(logic [7:0] c);
    case (phase)
      PH_HEADER: header_input(c);
      PH_BODY: begin
        push_result(0, c);
        if (remaining != 0) remaining--;
        if (remaining == 0) phase = PH_ENDPEND;
      end
      PH_CSIZE: begin
        if (prev_cr) begin
          prev_cr = 0;
          if (c == 8'h0a) begin
            remaining = number_value();
            number_clear();
            if (remaining == 0) begin
              final_chunk = 1;
              remaining = 2;
              phase = PH_CSKIP;
            end else phase = PH_CDATA;
            return;
          end
          number_char(8'h0d, 1);
        end
        if (c == 8'h0d) prev_cr = 1;
        else number_char(c, 1);
      end
      PH_CDATA: begin
        push_result(0, c);
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          remaining = 2;
          phase = PH_CSKIP;
        end
      end
      PH_CSKIP: begin
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          if (final_chunk) begin
            push_result(1, 0);
            response_clear();
          end else begin
            number_clear();
            prev_cr = 0;
            phase = PH_CSIZE;
          end
        end
      end
      default: begin
        push_result(1, 0);
        response_clear();
        header_input(c);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_result_t exp_r;
    if (!rst_ni) begin
      dflt_len = 32'd100;
      response_clear();
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0b byte=%02h chunked=%0b", $time,
                   result_kind_o, body_byte_o, chunked_mode_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== result_kind_o || exp_r.data !== body_byte_o ||
              exp_r.chunked !== chunked_mode_o) begin
            $display("%0t: mismatch expected kind=%0b byte=%02h chunked=%0b, got %0b %02h %0b",
                     $time, exp_r.kind, exp_r.data, exp_r.chunked, result_kind_o,
                     body_byte_o, chunked_mode_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push && !full) predict_byte(stream_byte_i);
      if (cfg_we_i) dflt_len = cfg_wdata_i;
    end
  end
endmodule

// File: tb/sv/tb_http_response_body_extractor_top.sv
// testbench top for the http response body extractor: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_http_response_body_extractor_top;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [7:0]  stream_byte_i = 0;
  logic        empty;
  logic        pop = 0;
  logic        result_kind_o;
  logic [7:0]  body_byte_o;
  logic        chunked_mode_o;
  logic        cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = 0;
  int          fail_count;
  int          pending;
  int          bytes_sent = 0;
  bit          hold_pop = 0;
  bit          bursty = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  http_response_body_extractor_top dut (.*);

  tb_http_response_body_extractor_checker chk (
    .clk_i, .rst_ni, .push, .full, .stream_byte_i, .empty, .pop, .result_kind_o,
    .body_byte_o, .chunked_mode_o, .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if (bursty) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver: random pops, with a long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pop) begin
        pop <= 0;
      end else begin
        g = gap_len();
        if (g == 0) pop <= 1;
        else begin
          pop <= 0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  // push stays high between back to back bytes and drops only before a gap
  task automatic send_byte(logic [7:0] b);
    int g;
    g = gap_len();
    if (g != 0) begin
      push <= 0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_default(logic [31:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic string rand_word(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'($urandom_range(8'h21, 8'h7e)))};
    return s;
  endfunction

  task automatic send_plain(int len, bit with_len);
    if ($urandom_range(0, 2) == 0) send_text({"X-", rand_word(3), ": v\r\n"});
    if (with_len) send_text($sformatf("Content-Length:%s%0d\r\n",
                                      $urandom_range(0, 1) ? " " : "\t", len));
    send_text("\r\n");
    repeat (len) send_byte($urandom_range(0, 255));
  endtask

  task automatic send_chunked();
    int n;
    int sz;
    send_text("Transfer-Encoding: chunked\r\n");
    if ($urandom_range(0, 1)) send_text("Content-Length: 3\r\n");
    send_text("\r\n");
    n = $urandom_range(0, 3);
    repeat (n) begin
      sz = $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0: send_text($sformatf("%0h\r\n", sz));
        1: send_text($sformatf("0x%0H;x\r\n", sz));
        default: send_text($sformatf(" +%0h\r\n", sz));
      endcase
      repeat (sz) send_byte($urandom_range(0, 255));
      send_byte($urandom_range(0, 255));
      send_byte($urandom_range(0, 255));
    end
    send_text("0\r\n");
    send_byte($urandom_range(0, 255));
    send_byte($urandom_range(0, 255));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: default length, zero, negative, saturated, odd lines
    write_default(3);
    send_text("\r\nabc");
    send_text("Content-Length: -5\r\n\r\n");
    send_text(":\r\nContent-Length\r\nA\rB: 1\r\nContent-Length: 2x\r\n\r\n");
    send_byte(8'h00); send_byte(8'hff);
    send_text("Content-Length: 99999999999\r\nContent-Length: +1\r\n\r\nZ");
    send_text("Transfer-Encoding:  chunked\r\nTransfer-Encoding: chunkedx\r\n\r\nqqq");
    send_text("Transfer-Encoding: chunked\r\n\r\n-3\rz\r\n0\r\nab");
    send_text("Transfer-Encoding: chunked\r\n\r\nFFFFFFFFFF\r\n");
    repeat (4) send_byte($urandom_range(0, 255));
    write_default(0);
    send_text("\r\n");
    write_default(32'hffffffff);
    send_text("Content-Length: 0\r\n\r\n");
    // receiver holds off while the sender keeps pushing
    write_default(100);
    hold_pop = 1;
    bursty = 1;
    fork
      begin
        repeat (60) @(negedge clk_i);
        hold_pop = 0;
      end
      send_plain(40, 1);
    join
    bursty = 0;
    drain();
    while (bytes_sent < 700) begin
      case ($urandom_range(0, 9))
        0: begin
          write_default($urandom_range(0, 20));
          send_plain(0, 0);
        end
        1: begin
          repeat ($urandom_range(1, 8)) send_byte($urandom_range(0, 255));
          send_text("\r\n\r\n");
          repeat ($urandom_range(0, 30)) send_byte($urandom_range(0, 255));
        end
        2, 3, 4: send_chunked();
        5: bursty = !bursty;
        default: send_plain($urandom_range(0, 15), 1);
      endcase
    end
    bursty = 0;
    // flush any open body with a default length of zero
    drain();
    write_default(0);
    send_text("\r\n\r\nContent-Length: 0\r\n\r\n");
    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule
